[rtl/mssr_pkg.sv]
// Package for the motor soft-start ramp: field widths, register reset values,
// mode, event and register-index codes. No dependencies; every other file imports it.
package mssr_pkg;

    localparam int DUTY_W   = 7;
    localparam int REQ_W    = 8;
    localparam int ACTION_W = 3;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0]  DUTY_FULL         = 7'd100;
    localparam logic [REQ_W-1:0]   REQ_FULL          = 8'd100;
    localparam logic [COUNT_W-1:0] COUNT_TOP         = 16'hFFFF;
    localparam logic [DUTY_W-1:0]  MIN_DUTY_RESET    = 7'd43;
    localparam logic [DUTY_W-1:0]  RAMP_STEP_RESET   = 7'd2;
    localparam logic [COUNT_W-1:0] RAMP_PERIOD_RESET = 16'd50;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_STOPPING = 2'd3
    } t_mode;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_START  = 3'd1,
        ACT_SOFT   = 3'd2,
        ACT_ESTOP  = 3'd3,
        ACT_TARGET = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DUTY    = 2'd0,
        CFG_RAMP_STEP   = 2'd1,
        CFG_RAMP_PERIOD = 2'd2
    } t_cfg_idx;

endpackage

[rtl/mssr_item_if.sv]
// Input channel of the motor soft-start ramp: one event per transaction.
// Depends on mssr_pkg for the field widths.
interface mssr_item_if;
    import mssr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [REQ_W-1:0]    duty_request;

    modport source (output valid, output action, output duty_request, input ready);
    modport sink   (input valid, input action, input duty_request, output ready);
endinterface

[rtl/mssr_result_if.sv]
// Result channel of the motor soft-start ramp: one status word per transaction.
// Depends on mssr_pkg for the field widths.
interface mssr_result_if;
    import mssr_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] present_duty;
    logic [DUTY_W-1:0] goal_duty;
    logic              duty_written;
    logic              driver_halt;

    modport source (output valid, output mode, output present_duty, output goal_duty,
                    output duty_written, output driver_halt, input ready);
    modport sink   (input valid, input mode, input present_duty, input goal_duty,
                    input duty_written, input driver_halt, output ready);
endinterface

[rtl/mssr_cfg_if.sv]
// Configuration write channel of the motor soft-start ramp: register index and data.
// Depends on mssr_pkg for the field widths.
interface mssr_cfg_if;
    import mssr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/motor_soft_start_ramp.sv]
// Motor soft-start duty sequencer. An accepted event is held in the input register, then its
// result in the result register. Throughput: one event per cycle; while a finished result
// waits, the input register takes one more event and then stalls.
// Synchronous active-low reset: mode stopped, both duties and the tick counter zero,
// registers at 43 / 2 / 50. Configuration writes are always taken.
// Depends on mssr_pkg and the three channel interfaces.
module motor_soft_start_ramp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mssr_item_if.sink       i_item,
    mssr_cfg_if.sink        i_cfg,
    mssr_result_if.source   o_result
);
    import mssr_pkg::*;

    // Configuration registers
    logic [DUTY_W-1:0]  r_min_duty;
    logic [DUTY_W-1:0]  r_ramp_step;
    logic [COUNT_W-1:0] r_ramp_period;

    // Input register
    logic               r_in_vld;
    t_action            r_in_action;
    logic [REQ_W-1:0]   r_in_req;

    // Sequencer state
    t_mode              r_mode, n_mode;
    logic [DUTY_W-1:0]  r_duty_now, n_duty_now;
    logic [DUTY_W-1:0]  r_duty_goal, n_duty_goal;
    logic [COUNT_W-1:0] r_ticks, n_ticks;

    // Result register
    logic               r_out_vld;
    t_mode              r_out_mode;
    logic [DUTY_W-1:0]  r_out_now;
    logic [DUTY_W-1:0]  r_out_goal;
    logic               r_out_written;
    logic               r_out_halt;

    logic               n_written;
    logic               n_halt;
    logic               out_free;
    logic               adv;
    logic [COUNT_W-1:0] ticks_inc;
    logic [DUTY_W-1:0]  toward_goal;
    logic [DUTY_W-1:0]  up_gap;
    logic [DUTY_W-1:0]  dn_gap;
    logic [DUTY_W-1:0]  req_clamped;

    assign out_free     = !r_out_vld || o_result.ready;
    assign adv          = r_in_vld && out_free;
    assign i_item.ready = !r_in_vld || out_free;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid        = r_out_vld;
    assign o_result.mode         = r_out_mode;
    assign o_result.present_duty = r_out_now;
    assign o_result.goal_duty    = r_out_goal;
    assign o_result.duty_written = r_out_written;
    assign o_result.driver_halt  = r_out_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty    <= MIN_DUTY_RESET;
            r_ramp_step   <= RAMP_STEP_RESET;
            r_ramp_period <= RAMP_PERIOD_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MIN_DUTY:    r_min_duty    <= i_cfg.data[DUTY_W-1:0];
                CFG_RAMP_STEP:   r_ramp_step   <= i_cfg.data[DUTY_W-1:0];
                CFG_RAMP_PERIOD: r_ramp_period <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_action <= t_action'(i_item.action);
            r_in_req    <= i_item.duty_request;
        end
    end

    // Duty one ramp step toward the goal; saturating tick increment; clamped goal request.
    always_comb begin
        up_gap      = r_duty_goal - r_duty_now;
        dn_gap      = r_duty_now - r_duty_goal;
        toward_goal = r_duty_now;
        if (r_duty_now < r_duty_goal) begin
            toward_goal = (up_gap <= r_ramp_step) ? r_duty_goal : r_duty_now + r_ramp_step;
        end else if (r_duty_now > r_duty_goal) begin
            toward_goal = (dn_gap <= r_ramp_step) ? r_duty_goal : r_duty_now - r_ramp_step;
        end
        ticks_inc = (r_ticks == COUNT_TOP) ? r_ticks : r_ticks + 1'b1;
        if (r_in_req > REQ_FULL) begin
            req_clamped = DUTY_FULL;
        end else begin
            req_clamped = r_in_req[DUTY_W-1:0];
        end
        if (req_clamped < r_min_duty) begin
            req_clamped = '0;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_duty_now  = r_duty_now;
        n_duty_goal = r_duty_goal;
        n_ticks     = r_ticks;
        n_written   = 1'b0;
        n_halt      = 1'b0;
        case (r_in_action)
            ACT_TICK: begin
                if (r_mode != MODE_STOPPED) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= r_ramp_period) begin
                        n_ticks   = '0;
                        n_written = 1'b1;
                        if (r_mode == MODE_STOPPING) begin
                            if (r_duty_now <= r_ramp_step) begin
                                n_duty_now = '0;
                                n_mode     = MODE_STOPPED;
                            end else begin
                                n_duty_now = r_duty_now - r_ramp_step;
                            end
                        end else begin
                            n_duty_now = toward_goal;
                            if (r_mode == MODE_STARTING && toward_goal == r_duty_goal) begin
                                n_mode = MODE_RUNNING;
                            end
                        end
                    end
                end
            end
            ACT_START: begin
                if (r_mode == MODE_STOPPED) begin
                    n_mode  = MODE_STARTING;
                    n_ticks = '0;
                end
            end
            ACT_SOFT: begin
                if (r_mode != MODE_STOPPED) begin
                    n_mode = MODE_STOPPING;
                end
            end
            ACT_ESTOP: begin
                n_duty_now  = '0;
                n_duty_goal = '0;
                n_mode      = MODE_STOPPED;
                n_halt      = 1'b1;
            end
            ACT_TARGET: begin
                n_duty_goal = req_clamped;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOPPED;
            r_duty_now  <= '0;
            r_duty_goal <= '0;
            r_ticks     <= '0;
        end else if (adv) begin
            r_mode      <= n_mode;
            r_duty_now  <= n_duty_now;
            r_duty_goal <= n_duty_goal;
            r_ticks     <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_mode    <= n_mode;
            r_out_now     <= n_duty_now;
            r_out_goal    <= n_duty_goal;
            r_out_written <= n_written;
            r_out_halt    <= n_halt;
        end
    end

    // The applied duty never exceeds full scale.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty_now <= DUTY_FULL)
        else $error("present duty above full scale");

    // The stopped mode is only reached with the duty at zero.
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_STOPPED |-> r_duty_now == '0)
        else $error("stopped mode with nonzero duty");

    // An emergency stop result reports a stopped motor with both duties cleared.
    a_halt_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.driver_halt |->
            o_result.mode == MODE_STOPPED && o_result.present_duty == '0 &&
            o_result.goal_duty == '0)
        else $error("driver halt with live duty");

    // A ramp step clears the tick counter.
    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_written |=> r_ticks == '0)
        else $error("tick counter not cleared after ramp step");

endmodule

[verif/motor_soft_start_ramp_tb.sv]
// Self-checking testbench for the motor soft-start duty sequencer: directed events,
// then random start/ramp/stop runs under several register settings, checked per result.
// Depends on mssr_pkg, the three channel interfaces and motor_soft_start_ramp.
module motor_soft_start_ramp_tb;
    import mssr_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int IDLE_PERCENT    = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int HALF_PHASE      = 35;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_UNUSED_MID = 3'd6;
    localparam logic [ACTION_W-1:0]  ACT_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [REQ_W-1:0]    duty_request;
    } motor_event_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    typedef struct packed {
        t_mode             mode;
        logic [DUTY_W-1:0] present_duty;
        logic [DUTY_W-1:0] goal_duty;
        logic              duty_written;
        logic              driver_halt;
    } duty_status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mssr_item_if   item_ch ();
    mssr_cfg_if    cfg_ch ();
    mssr_result_if res_ch ();

    motor_soft_start_ramp uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    motor_event_t pending_events[$];
    reg_write_t   pending_writes[$];
    duty_status_t expected_status[$];

    // Predicted sequencer state and register copies.
    t_mode              seq_mode;
    logic [DUTY_W-1:0]  duty_applied;
    logic [DUTY_W-1:0]  duty_target;
    logic [COUNT_W-1:0] tick_count;
    logic [DUTY_W-1:0]  min_duty_pct;
    logic [DUTY_W-1:0]  step_pct;
    logic [COUNT_W-1:0] period_ticks;

    int failures      = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int stall_left    = 0;
    int queued_items  = 0;
    bit idle_enable   = 1'b1;

    function automatic duty_status_t advance_sequencer(input logic [ACTION_W-1:0] act,
                                                       input logic [REQ_W-1:0] req);
        duty_status_t st;
        int now;
        int goal;
        int step;
        st   = '0;
        now  = int'(duty_applied);
        goal = int'(duty_target);
        step = int'(step_pct);
        case (act)
            ACT_TICK: begin
                if (seq_mode != MODE_STOPPED) begin
                    if (tick_count != COUNT_TOP)
                        tick_count = tick_count + 1'b1;
                    if (tick_count >= period_ticks) begin
                        tick_count = '0;
                        st.duty_written = 1'b1;
                        if (seq_mode == MODE_STOPPING) begin
                            if (now <= step) begin
                                now = 0;
                                seq_mode = MODE_STOPPED;
                            end else begin
                                now = now - step;
                            end
                        end else begin
                            if (goal - now > step)
                                now = now + step;
                            else if (now - goal > step)
                                now = now - step;
                            else
                                now = goal;
                            if (seq_mode == MODE_STARTING && now == goal)
                                seq_mode = MODE_RUNNING;
                        end
                    end
                end
            end
            ACT_START: begin
                if (seq_mode == MODE_STOPPED) begin
                    seq_mode = MODE_STARTING;
                    tick_count = '0;
                end
            end
            ACT_SOFT: begin
                if (seq_mode != MODE_STOPPED)
                    seq_mode = MODE_STOPPING;
            end
            ACT_ESTOP: begin
                now = 0;
                goal = 0;
                seq_mode = MODE_STOPPED;
                st.driver_halt = 1'b1;
            end
            ACT_TARGET: begin
                goal = (req > REQ_FULL) ? int'(REQ_FULL) : int'(req);
                if (goal < int'(min_duty_pct))
                    goal = 0;
            end
            default: ;
        endcase
        duty_applied    = now[DUTY_W-1:0];
        duty_target     = goal[DUTY_W-1:0];
        st.mode         = seq_mode;
        st.present_duty = duty_applied;
        st.goal_duty    = duty_target;
        return st;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Event driver: predicts each event when its transaction completes.
    always @(posedge clk) begin
        if (!rst_n) begin
            item_ch.valid        <= 1'b0;
            item_ch.action       <= ACT_TICK;
            item_ch.duty_request <= '0;
            seq_mode     = MODE_STOPPED;
            duty_applied = '0;
            duty_target  = '0;
            tick_count   = '0;
            min_duty_pct = MIN_DUTY_RESET;
            step_pct     = RAMP_STEP_RESET;
            period_ticks = RAMP_PERIOD_RESET;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                expected_status.push_back(
                    advance_sequencer(item_ch.action, item_ch.duty_request));
                void'(pending_events.pop_front());
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_events.size() != 0 &&
                    !(idle_enable && $urandom_range(99) < IDLE_PERCENT)) begin
                    item_ch.valid        <= 1'b1;
                    item_ch.action       <= pending_events[0].action;
                    item_ch.duty_request <= pending_events[0].duty_request;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_MIN_DUTY:    min_duty_pct = cfg_ch.data[DUTY_W-1:0];
                    CFG_RAMP_STEP:   step_pct = cfg_ch.data[DUTY_W-1:0];
                    CFG_RAMP_PERIOD: period_ticks = cfg_ch.data;
                    default: ;
                endcase
                void'(pending_writes.pop_front());
            end
            if (!cfg_ch.valid || cfg_ch.ready) begin
                if (pending_writes.size() != 0) begin
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= pending_writes[0].index;
                    cfg_ch.data  <= pending_writes[0].data;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; also drives ready, with random gaps and requested hold-offs.
    always @(posedge clk) begin
        duty_status_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_status.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, mode %0d duty %0d goal %0d", $time,
                             res_ch.mode, res_ch.present_duty, res_ch.goal_duty);
                end else begin
                    want = expected_status.pop_front();
                    check_field("mode", 16'(want.mode), 16'(res_ch.mode));
                    check_field("present_duty", 16'(want.present_duty),
                                16'(res_ch.present_duty));
                    check_field("goal_duty", 16'(want.goal_duty), 16'(res_ch.goal_duty));
                    check_field("duty_written", 16'(want.duty_written),
                                16'(res_ch.duty_written));
                    check_field("driver_halt", 16'(want.driver_halt),
                                16'(res_ch.driver_halt));
                end
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     expected_status.size());
            $display("FAIL motor_soft_start_ramp");
            $finish;
        end
    end

    function automatic logic [REQ_W-1:0] any_request();
        return REQ_W'($urandom_range(255));
    endfunction

    // Goal requests: anything, in range, or right around the minimum duty.
    function automatic logic [REQ_W-1:0] pick_request();
        int near;
        near = int'(min_duty_pct) + int'($urandom_range(4)) - 2;
        if (near < 0)
            near = 0;
        case ($urandom_range(2))
            0:       return any_request();
            1:       return REQ_W'($urandom_range(100));
            default: return REQ_W'(near);
        endcase
    endfunction

    task automatic queue_event(input logic [ACTION_W-1:0] act, input logic [REQ_W-1:0] req);
        motor_event_t ev;
        ev.action       = act;
        ev.duty_request = req;
        pending_events.push_back(ev);
        queued_items++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_event(ACT_TICK, any_request());
    endtask

    // Waits until every event has been sent and every result has come back.
    task automatic settle();
        do @(negedge clk);
        while (pending_events.size() != 0 || item_ch.valid || expected_status.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        reg_write_t wr;
        wr.index = idx;
        wr.data  = value;
        pending_writes.push_back(wr);
        do @(negedge clk);
        while (pending_writes.size() != 0 || cfg_ch.valid);
    endtask

    initial begin
        int phase;
        int half;
        int run_len;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_TICK;
        item_ch.duty_request = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_MIN_DUTY;
        cfg_ch.data          = '0;
        res_ch.ready         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values: goal clamping around 43 and a step after 50 ticks.
        queue_event(ACT_TARGET, 8'd42);
        queue_event(ACT_TARGET, 8'd43);
        queue_event(ACT_TARGET, 8'hFF);
        queue_event(ACT_TARGET, 8'd101);
        queue_event(ACT_TICK, 8'd0);
        queue_event(ACT_SOFT, 8'd0);
        queue_event(ACT_UNUSED_LO, 8'hFF);
        queue_event(ACT_UNUSED_MID, 8'h55);
        queue_event(ACT_UNUSED_HI, 8'hAA);
        queue_event(ACT_START, 8'd0);
        queue_event(ACT_START, 8'd0);
        queue_ticks(51);
        queue_event(ACT_SOFT, 8'd0);
        queue_event(ACT_ESTOP, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        settle();

        // Zero period and an oversized step: the duty jumps on every tick.
        write_reg(CFG_MIN_DUTY, 16'd0);
        write_reg(CFG_RAMP_STEP, 16'd127);
        write_reg(CFG_RAMP_PERIOD, 16'd0);
        queue_event(ACT_TARGET, 8'd0);
        queue_event(ACT_TARGET, 8'd100);
        queue_event(ACT_START, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        queue_event(ACT_TARGET, 8'd1);
        queue_event(ACT_TICK, 8'd0);
        queue_event(ACT_SOFT, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        settle();

        // Zero step: the duty never moves, but a stop at zero duty still completes.
        write_reg(CFG_RAMP_STEP, 16'd0);
        queue_event(ACT_TARGET, 8'd50);
        queue_event(ACT_START, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        queue_event(ACT_TARGET, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        queue_event(ACT_SOFT, 8'd0);
        queue_event(ACT_TICK, 8'd0);
        settle();

        // A minimum above full scale zeroes every goal; index 3 is no register.
        write_reg(CFG_MIN_DUTY, 16'd127);
        write_reg(CFG_NO_REG, 16'hFFFF);
        queue_event(ACT_TARGET, 8'd100);
        queue_event(ACT_TARGET, 8'hFF);
        settle();

        // Longest period: a burst of ticks without any idle cycles never reaches a step.
        idle_enable = 1'b0;
        write_reg(CFG_MIN_DUTY, 16'd0);
        write_reg(CFG_RAMP_STEP, 16'd100);
        write_reg(CFG_RAMP_PERIOD, 16'hFFFF);
        queue_event(ACT_TARGET, 8'd100);
        queue_event(ACT_START, 8'd0);
        queue_ticks(20);
        queue_event(ACT_ESTOP, 8'd0);
        settle();
        idle_enable = 1'b1;

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(3))
                0:       write_reg(CFG_MIN_DUTY, 16'd0);
                1:       write_reg(CFG_MIN_DUTY, 16'd100);
                default: write_reg(CFG_MIN_DUTY, 16'($urandom_range(100)));
            endcase
            case ($urandom_range(3))
                0:       write_reg(CFG_RAMP_STEP, 16'd1);
                1:       write_reg(CFG_RAMP_STEP, 16'd100);
                default: write_reg(CFG_RAMP_STEP, 16'($urandom_range(30, 2)));
            endcase
            case ($urandom_range(2))
                0:       write_reg(CFG_RAMP_PERIOD, 16'd1);
                default: write_reg(CFG_RAMP_PERIOD, 16'($urandom_range(6, 2)));
            endcase
            idle_enable = (phase != 2);
            for (half = 0; half < 2; half++) begin
                queued_items = 0;
                while (queued_items < HALF_PHASE) begin
                    if ($urandom_range(9) == 0) begin
                        queue_event(ACTION_W'($urandom_range(7)), any_request());
                    end else begin
                        // One start-to-stop run with goal changes along the way.
                        queue_event(ACT_TARGET, pick_request());
                        queue_event(ACT_START, any_request());
                        run_len = $urandom_range(20, 2);
                        repeat (run_len) begin
                            if ($urandom_range(9) == 0)
                                queue_event(ACT_TARGET, pick_request());
                            else
                                queue_event(ACT_TICK, any_request());
                        end
                        case ($urandom_range(9))
                            0, 1: queue_event(ACT_ESTOP, any_request());
                            2: ;
                            default: begin
                                queue_event(ACT_SOFT, any_request());
                                queue_ticks($urandom_range(20, 1));
                            end
                        endcase
                    end
                end
                // Stall the results while events keep coming so the block backs up.
                if (half == 0 && phase % 2 == 1)
                    hold_requests++;
                settle();
            end
        end

        repeat (10) @(negedge clk);
        if (failures == 0 && expected_status.size() == 0) begin
            $display("PASS motor_soft_start_ramp");
        end else begin
            $display("FAIL motor_soft_start_ramp");
        end
        $finish;
    end

endmodule
